>>> src/two_ended_bump_allocator_macros.svh
`ifndef TWO_ENDED_BUMP_ALLOCATOR_MACROS_SVH
`define TWO_ENDED_BUMP_ALLOCATOR_MACROS_SVH

// Checks a consequence in the same cycle as its antecedent.
`define TBA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define TBA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/tba_pkg.sv
package tba_pkg;

   localparam int SIZE_W     = 25;
   localparam int OFFSET_W   = 33;
   localparam int COUNT_W    = 34;
   localparam int FREE_OUT_W = 25;
   localparam int SEGCNT_W   = 10;
   localparam int STATUS_W   = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_MISALIGNED,
      STATUS_TOO_LARGE,
      STATUS_NO_SEGMENT
   } status_type;

   typedef struct packed {
      logic [SIZE_W-1:0] request_size;
      logic              allow_unaligned;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

   typedef struct packed {
      logic [OFFSET_W-1:0]   offset;
      status_type            status;
      logic                  opened_segment;
      logic [SEGCNT_W-1:0]   segment_count;
      logic [COUNT_W-1:0]    bytes_used;
      logic [FREE_OUT_W-1:0] bytes_free;
      logic [COUNT_W-1:0]    bytes_wasted;
      logic [COUNT_W-1:0]    bytes_small;
   } rsp_item_type;

endpackage

>>> src/tba_if.sv
interface tba_req_if import tba_pkg::*;;
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] request_size;
   logic              allow_unaligned;

   modport source (output valid, output request_size, output allow_unaligned, input ready);
   modport sink (input valid, input request_size, input allow_unaligned, output ready);
endinterface

interface tba_rsp_if import tba_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [OFFSET_W-1:0]   offset;
   logic [STATUS_W-1:0]   status;
   logic                  opened_segment;
   logic [SEGCNT_W-1:0]   segment_count;
   logic [COUNT_W-1:0]    bytes_used;
   logic [FREE_OUT_W-1:0] bytes_free;
   logic [COUNT_W-1:0]    bytes_wasted;
   logic [COUNT_W-1:0]    bytes_small;

   modport source (
      output valid, output offset, output status, output opened_segment,
      output segment_count, output bytes_used, output bytes_free,
      output bytes_wasted, output bytes_small, input ready
   );
   modport sink (
      input valid, input offset, input status, input opened_segment,
      input segment_count, input bytes_used, input bytes_free,
      input bytes_wasted, input bytes_small, output ready
   );
endinterface

>>> src/tba_align_stage.sv
module tba_align_stage import tba_pkg::*; #(
   parameter int ALIGN_BYTES = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  stage_type src_stage,
   output stage_type dst_stage,
   output logic      unaligned
);

   // Exact quotient by reciprocal multiplication for any size below 2**SIZE_W.
   localparam int              ALIGN_L = $clog2(ALIGN_BYTES);
   localparam int              SHIFT   = SIZE_W + ALIGN_L;
   localparam int              RECIP_W = SIZE_W + 2;
   localparam longint unsigned RECIP   =
      ((64'd1 << SHIFT) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
   localparam int              PROD_W  = SIZE_W + RECIP_W;
   localparam int              ALIGN_W = $clog2(ALIGN_BYTES + 1);
   localparam int              MUL_W   = SIZE_W + ALIGN_W;

   logic [PROD_W-1:0] product;
   logic [PROD_W-1:0] shifted;
   logic [SIZE_W-1:0] quot_in;
   logic [SIZE_W-1:0] quot_ff;
   logic [MUL_W-1:0]  back_product;
   stage_type         stage_ff;

   assign product = PROD_W'(src_stage.item.request_size) * PROD_W'(RECIP_W'(RECIP));
   assign shifted = product >> SHIFT;
   assign quot_in = shifted[SIZE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= src_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff.item <= src_stage.item;
         quot_ff       <= quot_in;
      end
   end

   assign back_product = MUL_W'(quot_ff) * MUL_W'(ALIGN_BYTES);
   assign unaligned    = back_product != MUL_W'(stage_ff.item.request_size);
   assign dst_stage    = stage_ff;

endmodule

>>> src/two_ended_bump_allocator.sv
// Each request passes the input, alignment and result registers in turn.
// One request is accepted every cycle; the input stalls only while a finished
// result beat waits on the output register and the consumer holds off.
// The quotient multiply for the alignment check and the allocator update each
// take one pipeline stage. Synchronous reset empties the pipeline and returns
// the allocator to segment zero with the header reserved.
module two_ended_bump_allocator import tba_pkg::*; #(
   parameter int SEGMENT_BYTES = 16777216,
   parameter int MAX_SEGS      = 512,
   parameter int ALIGN_BYTES   = 16,
   parameter int HEADER_BYTES  = 4096
) (
   input logic       clock,
   input logic       reset,
   tba_req_if.sink   req_bus,
   tba_rsp_if.source rsp_bus
);

   localparam int           FREE_W   = $clog2(SEGMENT_BYTES + 1);
   localparam int           CNT_W    = $clog2(MAX_SEGS + 1);
   localparam int           HDR_CLIP = (HEADER_BYTES > SEGMENT_BYTES) ?
                                       SEGMENT_BYTES : HEADER_BYTES;
   localparam [COUNT_W-1:0] SEG_34   = COUNT_W'(SEGMENT_BYTES);

   logic         advance;
   stage_type    s1_in;
   stage_type    s1_ff;
   stage_type    s2_stage;
   logic         unaligned;
   logic         commit;

   logic [COUNT_W-1:0] low_ff, low_in;
   logic [COUNT_W-1:0] high_ff, high_in;
   logic [COUNT_W-1:0] base_ff, base_in;
   logic [FREE_W-1:0]  free_ff, free_in;
   logic [COUNT_W-1:0] used_ff, used_in;
   logic [COUNT_W-1:0] wasted_ff, wasted_in;
   logic [COUNT_W-1:0] small_ff, small_in;
   logic [CNT_W-1:0]   segments_ff, segments_in;

   logic [COUNT_W-1:0] size34;
   logic               need_new;
   logic [COUNT_W-1:0] low_cur;
   logic [COUNT_W-1:0] high_cur;
   logic [COUNT_W-1:0] free_cur;
   logic [COUNT_W-1:0] free_next;
   logic [COUNT_W-1:0] free_ext;
   logic [SEGCNT_W:0]  seg_ext;
   status_type         status;
   logic [COUNT_W-1:0] offset_full;
   logic               opened;

   rsp_item_type rsp_in;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   assign s1_in.valid                = req_bus.valid;
   assign s1_in.item.request_size    = req_bus.request_size;
   assign s1_in.item.allow_unaligned = req_bus.allow_unaligned;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff.valid <= s1_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff.item <= s1_in.item;
      end
   end

   tba_align_stage #(
      .ALIGN_BYTES(ALIGN_BYTES)
   ) u_align_stage (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .src_stage (s1_ff),
      .dst_stage (s2_stage),
      .unaligned (unaligned)
   );

   always_comb begin
      low_in      = low_ff;
      high_in     = high_ff;
      base_in     = base_ff;
      free_in     = free_ff;
      used_in     = used_ff;
      wasted_in   = wasted_ff;
      small_in    = small_ff;
      segments_in = segments_ff;
      status      = STATUS_OK;
      offset_full = '0;
      opened      = 1'b0;
      need_new    = 1'b0;
      low_cur     = low_ff;
      high_cur    = high_ff;
      free_cur    = COUNT_W'(free_ff);
      free_next   = free_cur;
      size34      = COUNT_W'(s2_stage.item.request_size);

      if (unaligned && !s2_stage.item.allow_unaligned) begin
         status = STATUS_MISALIGNED;
      end else if (size34 > SEG_34) begin
         status = STATUS_TOO_LARGE;
      end else begin
         need_new = size34 > COUNT_W'(free_ff);
         if (need_new && (segments_ff >= CNT_W'(MAX_SEGS))) begin
            status = STATUS_NO_SEGMENT;
         end else begin
            if (need_new) begin
               wasted_in   = wasted_ff + COUNT_W'(free_ff);
               free_cur    = SEG_34;
               low_cur     = base_ff;
               high_cur    = base_ff + SEG_34;
               base_in     = base_ff + SEG_34;
               segments_in = segments_ff + CNT_W'(1);
               opened      = 1'b1;
            end
            if (unaligned) begin
               high_in     = high_cur - size34;
               low_in      = low_cur;
               offset_full = high_in;
               small_in    = small_ff + size34;
            end else begin
               high_in     = high_cur;
               low_in      = low_cur + size34;
               offset_full = low_cur;
            end
            free_next = free_cur - size34;
            free_in   = free_next[FREE_W-1:0];
            used_in   = used_ff + size34;
         end
      end
   end

   assign free_ext = COUNT_W'(free_in);
   assign seg_ext  = (SEGCNT_W + 1)'(segments_in);

   always_comb begin
      rsp_in.offset         = offset_full[OFFSET_W-1:0];
      rsp_in.status         = status;
      rsp_in.opened_segment = opened;
      rsp_in.segment_count  = seg_ext[SEGCNT_W-1:0];
      rsp_in.bytes_used     = used_in;
      rsp_in.bytes_free     = free_ext[FREE_OUT_W-1:0];
      rsp_in.bytes_wasted   = wasted_in;
      rsp_in.bytes_small    = small_in;
   end

   assign commit = s2_stage.valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff      <= COUNT_W'(HDR_CLIP);
         high_ff     <= SEG_34;
         base_ff     <= SEG_34;
         free_ff     <= FREE_W'(SEGMENT_BYTES - HDR_CLIP);
         used_ff     <= COUNT_W'(HEADER_BYTES);
         wasted_ff   <= '0;
         small_ff    <= '0;
         segments_ff <= CNT_W'(1);
      end else if (commit) begin
         low_ff      <= low_in;
         high_ff     <= high_in;
         base_ff     <= base_in;
         free_ff     <= free_in;
         used_ff     <= used_in;
         wasted_ff   <= wasted_in;
         small_ff    <= small_in;
         segments_ff <= segments_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.offset         = rsp_ff.offset;
   assign rsp_bus.status         = rsp_ff.status;
   assign rsp_bus.opened_segment = rsp_ff.opened_segment;
   assign rsp_bus.segment_count  = rsp_ff.segment_count;
   assign rsp_bus.bytes_used     = rsp_ff.bytes_used;
   assign rsp_bus.bytes_free     = rsp_ff.bytes_free;
   assign rsp_bus.bytes_wasted   = rsp_ff.bytes_wasted;
   assign rsp_bus.bytes_small    = rsp_ff.bytes_small;

endmodule

>>> src/tba_checker.sv
`include "two_ended_bump_allocator_macros.svh"

module tba_checker import tba_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [OFFSET_W-1:0] rsp_offset,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_opened_segment,
   input logic [COUNT_W-1:0]  rsp_bytes_used
);

   // A stalled result beat stays valid and keeps its offset and bytes used.
   `TBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_offset) && $stable(rsp_bytes_used), "stalled result beat changed")

   // A failed request grants nothing and opens nothing.
   `TBA_ASSERT_SAME(a_error_clean, rsp_valid && (rsp_status != STATUS_OK), (rsp_offset == '0) && !rsp_opened_segment, "error beat carries an offset or an opened segment")

   // Only a successful request may open a segment.
   `TBA_ASSERT_SAME(a_open_ok, rsp_valid && rsp_opened_segment, rsp_status == STATUS_OK, "segment opened by a failed request")

   // With the output register empty the pipeline always takes a request.
   `TBA_ASSERT_SAME(a_ready_when_empty, !rsp_valid, req_ready, "input stalled while the output is empty")

endmodule

bind two_ended_bump_allocator tba_checker u_tba_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_offset         (rsp_bus.offset),
   .rsp_status         (rsp_bus.status),
   .rsp_opened_segment (rsp_bus.opened_segment),
   .rsp_bytes_used     (rsp_bus.bytes_used)
);

>>> tb/tb_two_ended_bump_allocator.sv
module tb_two_ended_bump_allocator import tba_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEGMENT_BYTES = 16777216;
   localparam int MAX_SEGS      = 512;
   localparam int ALIGN_BYTES   = 16;
   localparam int HEADER_BYTES  = 4096;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int MAX_GAP       = 18;

   localparam logic [COUNT_W-1:0] SEG34 = COUNT_W'(SEGMENT_BYTES);

   class alloc_ledger;
      logic [COUNT_W-1:0] low_ptr;
      logic [COUNT_W-1:0] high_ptr;
      logic [COUNT_W-1:0] free_bytes;
      logic [COUNT_W-1:0] used_bytes;
      logic [COUNT_W-1:0] wasted_bytes;
      logic [COUNT_W-1:0] small_bytes;
      int unsigned        seg_open;
      rsp_item_type       expected_grants[$];
      int unsigned        errors;

      function new();
         logic [COUNT_W-1:0] hdr;
         hdr = COUNT_W'(HEADER_BYTES);
         if (hdr > SEG34) begin
            hdr = SEG34;
         end
         low_ptr      = hdr;
         high_ptr     = SEG34;
         free_bytes   = SEG34 - hdr;
         used_bytes   = COUNT_W'(HEADER_BYTES);
         wasted_bytes = '0;
         small_bytes  = '0;
         seg_open     = 1;
         errors       = 0;
      endfunction

      function logic [COUNT_W-1:0] room();
         return high_ptr - low_ptr;
      endfunction

      function void note_request(req_item_type req);
         logic [COUNT_W-1:0] size;
         logic               misaligned;
         logic               need_new;
         rsp_item_type       grant;
         size       = COUNT_W'(req.request_size);
         misaligned = (size % COUNT_W'(ALIGN_BYTES)) != 0;
         grant      = '0;
         grant.status = STATUS_OK;
         if (misaligned && !req.allow_unaligned) begin
            grant.status = STATUS_MISALIGNED;
         end else if (size > SEG34) begin
            grant.status = STATUS_TOO_LARGE;
         end else begin
            need_new = size > (high_ptr - low_ptr);
            if (need_new && seg_open >= MAX_SEGS) begin
               grant.status = STATUS_NO_SEGMENT;
            end else begin
               if (need_new) begin
                  wasted_bytes = wasted_bytes + free_bytes;
                  free_bytes   = SEG34;
                  low_ptr      = COUNT_W'(seg_open) * SEG34;
                  high_ptr     = low_ptr + SEG34;
                  seg_open     = seg_open + 1;
                  grant.opened_segment = 1'b1;
               end
               if (misaligned) begin
                  high_ptr     = high_ptr - size;
                  grant.offset = high_ptr[OFFSET_W-1:0];
                  small_bytes  = small_bytes + size;
               end else begin
                  grant.offset = low_ptr[OFFSET_W-1:0];
                  low_ptr      = low_ptr + size;
               end
               free_bytes = free_bytes - size;
               used_bytes = used_bytes + size;
            end
         end
         grant.segment_count = SEGCNT_W'(seg_open);
         grant.bytes_used    = used_bytes;
         grant.bytes_free    = free_bytes[FREE_OUT_W-1:0];
         grant.bytes_wasted  = wasted_bytes;
         grant.bytes_small   = small_bytes;
         expected_grants.push_back(grant);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) begin
            $display("ERROR at %0t: %s", $time, msg);
         end
      endtask

      task compare(string name, logic [COUNT_W-1:0] got, logic [COUNT_W-1:0] want);
         if (got !== want) begin
            report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
         end
      endtask

      task check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_grants.size() == 0) begin
            report("result beat arrived with no request outstanding");
            return;
         end
         want = expected_grants.pop_front();
         compare("offset", COUNT_W'(got.offset), COUNT_W'(want.offset));
         compare("status", COUNT_W'(got.status), COUNT_W'(want.status));
         compare("opened_segment", COUNT_W'(got.opened_segment),
                 COUNT_W'(want.opened_segment));
         compare("segment_count", COUNT_W'(got.segment_count),
                 COUNT_W'(want.segment_count));
         compare("bytes_used", got.bytes_used, want.bytes_used);
         compare("bytes_free", COUNT_W'(got.bytes_free), COUNT_W'(want.bytes_free));
         compare("bytes_wasted", got.bytes_wasted, want.bytes_wasted);
         compare("bytes_small", got.bytes_small, want.bytes_small);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   req_calm;
   bit   rsp_calm;

   alloc_ledger ledger = new();

   tba_req_if req_bus();
   tba_rsp_if rsp_bus();

   two_ended_bump_allocator #(
      .SEGMENT_BYTES(SEGMENT_BYTES),
      .MAX_SEGS(MAX_SEGS),
      .ALIGN_BYTES(ALIGN_BYTES),
      .HEADER_BYTES(HEADER_BYTES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #5 clock = ~clock;

   function automatic req_item_type make_request(logic [SIZE_W-1:0] size, logic allow);
      req_item_type it;
      it.request_size    = size;
      it.allow_unaligned = allow;
      return it;
   endfunction

   function automatic req_item_type random_request();
      int unsigned pick;
      int unsigned size;
      logic        allow;
      pick  = $urandom_range(0, 99);
      allow = 1'($urandom_range(0, 1));
      if (pick < 33) begin
         size = SEGMENT_BYTES - ALIGN_BYTES * $urandom_range(0, 4096);
      end else if (pick < 36) begin
         size = SEGMENT_BYTES;
      end else if (pick < 56) begin
         size = ALIGN_BYTES * $urandom_range(0, 4096);
      end else if (pick < 70) begin
         size  = $urandom_range(1, 200000);
         size  = (size % ALIGN_BYTES == 0) ? size + 1 : size;
         allow = 1'b1;
      end else if (pick < 77) begin
         size  = $urandom() & 32'h01FF_FFFF;
         size  = (size % ALIGN_BYTES == 0) ? size | 1 : size;
         allow = 1'b0;
      end else if (pick < 82) begin
         size = $urandom_range(SEGMENT_BYTES + 1, (1 << SIZE_W) - 1);
      end else if (pick < 85) begin
         size = 0;
      end else if (pick < 90) begin
         size  = 32'(ledger.room()) + ALIGN_BYTES * $urandom_range(0, 1);
         allow = 1'b1;
      end else begin
         size = $urandom() & 32'h01FF_FFFF;
      end
      return make_request(SIZE_W'(size), allow);
   endfunction

   task automatic send_request(req_item_type it);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.request_size    <= it.request_size;
      req_bus.allow_unaligned <= it.allow_unaligned;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      ledger.note_request(it);
   endtask

   initial begin
      int gap;
      int beats;
      rsp_item_type got;
      beats = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (beats % 120 == 0) begin
            rsp_calm = ($urandom_range(0, 3) == 0);
         end
         gap = rsp_calm ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do begin
            @(posedge clock);
         end while (!rsp_bus.valid);
         got.offset         = rsp_bus.offset;
         got.status         = status_type'(rsp_bus.status);
         got.opened_segment = rsp_bus.opened_segment;
         got.segment_count  = rsp_bus.segment_count;
         got.bytes_used     = rsp_bus.bytes_used;
         got.bytes_free     = rsp_bus.bytes_free;
         got.bytes_wasted   = rsp_bus.bytes_wasted;
         got.bytes_small    = rsp_bus.bytes_small;
         ledger.check_result(got);
         beats++;
      end
   end

   initial begin
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.request_size    <= '0;
      req_bus.allow_unaligned <= 1'b0;
      req_calm = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The misaligned check wins over the size check.
      send_request(make_request(SIZE_W'(0), 1'b0));
      send_request(make_request(SIZE_W'(16), 1'b0));
      send_request(make_request(SIZE_W'(1), 1'b0));
      send_request(make_request(SIZE_W'(1), 1'b1));
      send_request(make_request(SIZE_W'(15), 1'b1));
      send_request(make_request(25'h1FF_FFFF, 1'b0));
      send_request(make_request(25'h1FF_FFFF, 1'b1));
      send_request(make_request(25'h1FF_FFF0, 1'b0));
      send_request(make_request(SIZE_W'(SEGMENT_BYTES + ALIGN_BYTES), 1'b1));
      send_request(make_request(SIZE_W'(SEGMENT_BYTES + 1), 1'b1));
      send_request(make_request(SIZE_W'(SEGMENT_BYTES), 1'b0));
      send_request(make_request(SIZE_W'(0), 1'b1));
      send_request(make_request(SIZE_W'(16), 1'b0));
      send_request(make_request(SIZE_W'(SEGMENT_BYTES - 32), 1'b1));
      send_request(make_request(SIZE_W'(ledger.room()), 1'b0));
      send_request(make_request(SIZE_W'(17), 1'b1));
      send_request(make_request(SIZE_W'(ledger.room()), 1'b1));
      send_request(make_request(25'h0AA_AAAA, 1'b1));
      send_request(make_request(25'h055_5550, 1'b0));
      send_request(make_request(SIZE_W'(ledger.room() + 1), 1'b1));
      send_request(make_request(SIZE_W'(SEGMENT_BYTES - 1), 1'b1));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) begin
            req_calm = ($urandom_range(0, 3) == 0);
         end
         send_request(random_request());
      end
      req_bus.valid <= 1'b0;

      while (ledger.expected_grants.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (ledger.errors == 0) begin
         $display("PASS two_ended_bump_allocator");
      end else begin
         $display("FAIL two_ended_bump_allocator");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL two_ended_bump_allocator");
      $finish;
   end

endmodule
